// ===== sv/gpig_pkg.sv =====
package gpig_pkg;

  localparam int MAX_SIDE_VERTICES = 257;

  localparam int SIDE_W  = 9;
  localparam int LOD_W   = 8;
  localparam int CELL_W  = 7;
  localparam int INDEX_W = 17;

  // major*2*lod
  localparam int ROW_W   = CELL_W + LOD_W + 1;
  // side*lod and side*side
  localparam int STEP_W  = 17;
  localparam int LIMIT_W = 17;
  // full-precision vertex index: corner plus up to two steps on each axis
  localparam int VERT_W  = 25;

  localparam int NUM_VERTS         = 9;
  localparam int VSEL_W            = 4;
  localparam int RESULTS_PER_PATCH = 24;
  localparam int CNT_W             = 5;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SIDE_W;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd2;

  localparam logic MODE_PAIRED = 1'b0;
  localparam logic MODE_FAN    = 1'b1;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 9'd65;
  localparam logic [LOD_W-1:0]  LOD_RESET  = 8'd1;

  // vertex letters a..i map to 0..8
  localparam logic [VSEL_W-1:0] ORDER_PAIRED [RESULTS_PER_PATCH] = '{
    4'd0, 4'd1, 4'd4,  4'd5, 4'd0, 4'd4,  4'd1, 4'd2, 4'd4,  4'd4, 4'd2, 4'd3,
    4'd4, 4'd3, 4'd8,  4'd7, 4'd4, 4'd8,  4'd5, 4'd4, 4'd6,  4'd6, 4'd4, 4'd7
  };
  localparam logic [VSEL_W-1:0] ORDER_FAN [RESULTS_PER_PATCH] = '{
    4'd4, 4'd5, 4'd0,  4'd4, 4'd0, 4'd1,  4'd4, 4'd1, 4'd2,  4'd4, 4'd2, 4'd3,
    4'd4, 4'd3, 4'd8,  4'd4, 4'd8, 4'd7,  4'd4, 4'd7, 4'd6,  4'd4, 4'd6, 4'd5
  };

  typedef struct packed {
    logic [SIDE_W-1:0] side;
    logic [LOD_W-1:0]  lod;
    logic              mode;
  } cfg_t;

  typedef struct packed {
    logic [VERT_W-1:0]  corner;
    logic [STEP_W-1:0]  step1;
    logic [STEP_W-1:0]  step2;
    logic [LIMIT_W-1:0] limit;
    logic               mode;
  } patch_base_t;

  function automatic logic [VSEL_W-1:0] vertex_sel(input logic mode,
                                                   input logic [CNT_W-1:0] k);
    logic [VSEL_W-1:0] sel;
    if (mode == MODE_FAN) begin
      sel = ORDER_FAN[k];
    end else begin
      sel = ORDER_PAIRED[k];
    end
    return sel;
  endfunction

endpackage

// ===== sv/gpig_if.sv =====
interface gpig_in_if;
  import gpig_pkg::*;
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_major;
  logic [CELL_W-1:0] cell_minor;

  modport source (output valid, output cell_major, output cell_minor, input ready);
  modport sink   (input valid, input cell_major, input cell_minor, output ready);
endinterface

interface gpig_out_if;
  import gpig_pkg::*;
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] vertex_index;
  logic               beyond_grid;
  logic               last_of_patch;

  modport source (output valid, output vertex_index, output beyond_grid,
                  output last_of_patch, input ready);
  modport sink   (input valid, input vertex_index, input beyond_grid,
                  input last_of_patch, output ready);
endinterface

// ===== sv/grid_patch_index_generator.sv =====
// Grid patch index generator. Each input transaction carries one patch position
// (cell_major, cell_minor); the block answers with 24 vertex indices, eight
// triangles over a 2x2 patch of a square grid of grid_side_vertices per side at
// stride lod_step, with last_of_patch set on the 24th. A side above 257 is
// treated as 257. Output runs at one index per cycle unless the result channel
// stalls it through out_ch.ready; the next patch is taken in while the current
// one is still being emitted, keeping the output busy back to back. The first
// index of a patch passes through input capture, two arithmetic stages, the
// patch register and then the output register after its input transaction is
// accepted. Configuration is sampled when a patch is accepted and must only
// change while the block is idle.
module grid_patch_index_generator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [gpig_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gpig_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  gpig_in_if.sink                           in_ch,
  gpig_out_if.source                        out_ch
);
  import gpig_pkg::*;

  cfg_t        cfg_r;
  patch_base_t base;
  logic        base_valid, base_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.side <= SIDE_RESET;
      cfg_r.lod  <= LOD_RESET;
      cfg_r.mode <= MODE_PAIRED;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIDE: cfg_r.side <= cfg_wdata[SIDE_W-1:0];
        CFG_LOD:  cfg_r.lod  <= cfg_wdata[LOD_W-1:0];
        CFG_MODE: cfg_r.mode <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  gpig_addr_pipe u_addr_pipe (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_ch        (in_ch),
    .base_o       (base),
    .base_valid_o (base_valid),
    .base_ready_i (base_ready)
  );

  gpig_emitter u_emitter (
    .clk          (clk),
    .rst_n        (rst_n),
    .base_i       (base),
    .base_valid_i (base_valid),
    .base_ready_o (base_ready),
    .out_ch       (out_ch)
  );

endmodule

// ===== sv/gpig_addr_pipe.sv =====
module gpig_addr_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  gpig_pkg::cfg_t      cfg,
  gpig_in_if.sink             in_ch,
  output gpig_pkg::patch_base_t base_o,
  output logic                base_valid_o,
  input  logic                base_ready_i
);
  import gpig_pkg::*;

  // stage 1: captured transaction and config snapshot
  logic              s1_v_r;
  logic [CELL_W-1:0] s1_major_r, s1_minor_r;
  logic [SIDE_W-1:0] s1_side_r;
  logic [LOD_W-1:0]  s1_lod_r;
  logic              s1_mode_r;

  // stage 2: small products
  logic               s2_v_r;
  logic [ROW_W-1:0]   s2_row_r, s2_col_r;
  logic [STEP_W-1:0]  s2_step_r;
  logic [LIMIT_W-1:0] s2_limit_r;
  logic [SIDE_W-1:0]  s2_side_r;
  logic [LOD_W-1:0]   s2_lod_r;
  logic               s2_mode_r;

  // stage 3: corner and axis steps
  logic        s3_v_r;
  patch_base_t s3_r, s3_nxt;

  logic rdy1, rdy2, rdy3;
  logic [SIDE_W-1:0]        side_sat;
  logic [CELL_W+LOD_W-1:0]  maj_l, min_l;
  logic [STEP_W-1:0]        step_nxt;
  logic [LIMIT_W-1:0]       limit_nxt;

  assign rdy3 = !s3_v_r || base_ready_i;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;
  assign in_ch.ready = rdy1;

  assign side_sat = (cfg.side > SIDE_W'(MAX_SIDE_VERTICES)) ?
                    SIDE_W'(MAX_SIDE_VERTICES) : cfg.side;

  assign maj_l     = (CELL_W+LOD_W)'(s1_major_r) * (CELL_W+LOD_W)'(s1_lod_r);
  assign min_l     = (CELL_W+LOD_W)'(s1_minor_r) * (CELL_W+LOD_W)'(s1_lod_r);
  assign step_nxt  = STEP_W'(s1_side_r) * STEP_W'(s1_lod_r);
  assign limit_nxt = LIMIT_W'(s1_side_r) * LIMIT_W'(s1_side_r);

  always_comb begin
    s3_nxt.corner = VERT_W'(s2_row_r) * VERT_W'(s2_side_r) + VERT_W'(s2_col_r);
    s3_nxt.limit  = s2_limit_r;
    s3_nxt.mode   = s2_mode_r;
    if (s2_mode_r == MODE_FAN) begin
      s3_nxt.step1 = s2_step_r;
      s3_nxt.step2 = STEP_W'(s2_lod_r);
    end else begin
      s3_nxt.step1 = STEP_W'(s2_lod_r);
      s3_nxt.step2 = s2_step_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r <= in_ch.valid;
      if (rdy2) s2_v_r <= s1_v_r;
      if (rdy3) s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_ch.valid) begin
      s1_major_r <= in_ch.cell_major;
      s1_minor_r <= in_ch.cell_minor;
      s1_side_r  <= side_sat;
      s1_lod_r   <= cfg.lod;
      s1_mode_r  <= cfg.mode;
    end
    if (rdy2 && s1_v_r) begin
      s2_row_r   <= {maj_l, 1'b0};
      s2_col_r   <= {min_l, 1'b0};
      s2_step_r  <= step_nxt;
      s2_limit_r <= limit_nxt;
      s2_side_r  <= s1_side_r;
      s2_lod_r   <= s1_lod_r;
      s2_mode_r  <= s1_mode_r;
    end
    if (rdy3 && s2_v_r) begin
      s3_r <= s3_nxt;
    end
  end

  assign base_o       = s3_r;
  assign base_valid_o = s3_v_r;

endmodule

// ===== sv/gpig_emitter.sv =====
module gpig_emitter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gpig_pkg::patch_base_t base_i,
  input  logic                  base_valid_i,
  output logic                  base_ready_o,
  gpig_out_if.source            out_ch
);
  import gpig_pkg::*;

  logic               patch_v_r;
  logic [VERT_W-1:0]  verts_r [NUM_VERTS];
  logic [VERT_W-1:0]  verts_nxt [NUM_VERTS];
  logic [LIMIT_W-1:0] limit_r;
  logic               mode_r;
  logic [CNT_W-1:0]   k_r;

  logic               out_v_r;
  logic [INDEX_W-1:0] out_idx_r;
  logic               out_beyond_r;
  logic               out_last_r;

  logic [VERT_W-1:0] a, s1, s2, s1x2, s2x2, cur;
  logic [VSEL_W-1:0] sel;
  logic out_adv, emit, last_k, load;

  assign a    = base_i.corner;
  assign s1   = VERT_W'(base_i.step1);
  assign s2   = VERT_W'(base_i.step2);
  assign s1x2 = {s1[VERT_W-2:0], 1'b0};
  assign s2x2 = {s2[VERT_W-2:0], 1'b0};

  always_comb begin
    verts_nxt[0] = a;
    verts_nxt[1] = a + s1;
    verts_nxt[2] = a + s1x2;
    verts_nxt[3] = a + s1x2 + s2;
    verts_nxt[4] = a + s1 + s2;
    verts_nxt[5] = a + s2;
    verts_nxt[6] = a + s2x2;
    verts_nxt[7] = a + s2x2 + s1;
    verts_nxt[8] = a + s2x2 + s1x2;
  end

  assign out_adv      = !out_v_r || out_ch.ready;
  assign emit         = patch_v_r && out_adv;
  assign last_k       = (k_r == CNT_W'(RESULTS_PER_PATCH - 1));
  assign base_ready_o = !patch_v_r || (emit && last_k);
  assign load         = base_valid_i && base_ready_o;

  assign sel = vertex_sel(mode_r, k_r);
  assign cur = verts_r[sel];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      patch_v_r <= 1'b0;
      k_r       <= '0;
      out_v_r   <= 1'b0;
    end else begin
      if (load) begin
        patch_v_r <= 1'b1;
      end else if (emit && last_k) begin
        patch_v_r <= 1'b0;
      end
      if (emit) begin
        k_r <= last_k ? '0 : k_r + 1'b1;
      end
      if (out_adv) out_v_r <= patch_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      verts_r <= verts_nxt;
      limit_r <= base_i.limit;
      mode_r  <= base_i.mode;
    end
    if (emit) begin
      out_idx_r    <= cur[INDEX_W-1:0];
      out_beyond_r <= (cur >= VERT_W'(limit_r));
      out_last_r   <= last_k;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.vertex_index  = out_idx_r;
  assign out_ch.beyond_grid   = out_beyond_r;
  assign out_ch.last_of_patch = out_last_r;

  // counter only runs while a patch is held
  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    k_r != '0 |-> patch_v_r)
    else $error("index counter running without a patch");

  // emitting the 24th index rewinds the counter
  a_cnt_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    emit && last_k |=> k_r == '0)
    else $error("index counter did not wrap after last index");

  // every emitted index lands in the output register
  a_out_full: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_v_r)
    else $error("emitted index lost");

endmodule
